// File: sv/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Fixed field widths
  localparam int OFFSET_W = 11;
  localparam int ADDR_W   = 11;
  localparam int BYTE_W   = 8;
  localparam int CELL_W   = 16;

  // Item function codes
  localparam logic [2:0] FUNC_PUT   = 3'd0;
  localparam logic [2:0] FUNC_ERASE = 3'd1;
  localparam logic [2:0] FUNC_CLEAR = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Character codes and blank attribute after reset
  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] TAB_CODE     = 8'd9;
  localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [BYTE_W-1:0] FILL_RESET   = 8'd7;
  localparam int                TAB_STOP     = 8;

  // Register port
  localparam int         PADDR_W         = 3;
  localparam int         PDATA_W         = 32;
  localparam logic [0:0] REG_FILL_ATTR   = 1'b0;

  typedef struct packed {
    logic [2:0]        func;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] attribute;
    logic [ADDR_W-1:0] cell_address;
  } item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] cursor_offset;
    logic [BYTE_W-1:0]   read_char;
    logic [BYTE_W-1:0]   read_attribute;
    logic                scrolled;
  } result_t;

  // Cursor unit operations
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_PUT,
    CUR_ERASE,
    CUR_HOME,
    CUR_UP
  } cur_op_t;

  typedef struct packed {
    cur_op_t           op;
    logic [BYTE_W-1:0] char_code;
  } cur_cmd_t;

endpackage

`default_nettype wire

// File: sv/tcw_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/tcw_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor #(
  parameter int COLS  = 80,
  parameter int CELLS = 2000,
  parameter int CW    = 11
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcw_pkg::cur_cmd_t  cmd,
  output logic      [CW-1:0]      cursor,
  output logic      [CW-1:0]      cursor_dec,
  output logic                    cursor_zero,
  output logic                    scroll_need
);

  localparam int COLW = $clog2(COLS);
  localparam int AW   = COLW + 1;
  localparam int SW   = CW + 2;

  logic [COLW-1:0] col;
  logic [CW-1:0]   cursor_next;
  logic [COLW-1:0] col_next;
  logic [AW-1:0]   adv;
  logic [AW-1:0]   col_sum;
  logic [COLW-1:0] col_put;
  logic [COLW-1:0] col_dec;
  logic [SW-1:0]   sum_put;
  logic            newline;

  // Advance of a put: to row end, to next tab stop, or one cell
  always_comb begin
    newline = (cmd.char_code == tcw_pkg::NEWLINE_CODE);
    if (newline) begin
      adv = AW'(COLS) - {1'b0, col};
    end else if (cmd.char_code == tcw_pkg::TAB_CODE) begin
      adv = AW'(tcw_pkg::TAB_STOP) - AW'(cursor[2:0]);
    end else begin
      adv = AW'(1);
    end
    sum_put = SW'(cursor) + SW'(adv);
    col_sum = {1'b0, col} + adv;
    if (newline) begin
      col_put = '0;
    end else if (col_sum >= AW'(COLS)) begin
      col_put = COLW'(col_sum - AW'(COLS));
    end else begin
      col_put = COLW'(col_sum);
    end
  end

  assign scroll_need = (sum_put + SW'(COLS)) >= SW'(CELLS);
  assign cursor_dec  = cursor - 1'b1;
  assign cursor_zero = (cursor == '0);
  assign col_dec     = (col == '0) ? COLW'(COLS - 1) : col - 1'b1;

  // Select next cursor and column
  always_comb begin
    cursor_next = cursor;
    col_next    = col;
    unique case (cmd.op)
      tcw_pkg::CUR_PUT: begin
        cursor_next = CW'(sum_put);
        col_next    = col_put;
      end
      tcw_pkg::CUR_ERASE: begin
        cursor_next = cursor_dec;
        col_next    = col_dec;
      end
      tcw_pkg::CUR_HOME: begin
        cursor_next = '0;
        col_next    = '0;
      end
      tcw_pkg::CUR_UP: begin
        if (SW'(cursor) >= SW'(COLS)) begin
          cursor_next = cursor - CW'(COLS);
        end else begin
          cursor_next = '0;
          col_next    = '0;
        end
      end
      default: begin
        cursor_next = cursor;
        col_next    = col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      col    <= '0;
    end else begin
      cursor <= cursor_next;
      col    <= col_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
  parameter int COLS  = 80,
  parameter int CELLS = 2000,
  parameter int CW    = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire tcw_pkg::item_t                    item,
  input  wire logic [tcw_pkg::BYTE_W-1:0]        fill_attr,
  input  wire logic [CW-1:0]                     cursor,
  input  wire logic [CW-1:0]                     cursor_dec,
  input  wire logic                              cursor_zero,
  input  wire logic                              scroll_need,
  input  wire logic [tcw_pkg::CELL_W-1:0]        rdata,
  output logic                                   busy,
  output logic                                   done,
  output tcw_pkg::result_t                       result,
  output tcw_pkg::cur_cmd_t                      cmd,
  output logic                                   we,
  output logic      [CW-1:0]                     waddr,
  output logic      [tcw_pkg::CELL_W-1:0]        wdata,
  output logic      [CW-1:0]                     raddr
);

  localparam int          XW        = ((CW > tcw_pkg::ADDR_W) ? CW : tcw_pkg::ADDR_W) + 1;
  localparam logic [CW-1:0] LAST      = CW'(CELLS - 1);
  localparam logic [CW-1:0] COPY_LAST = CW'(CELLS - 2 * COLS - 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_COPY  = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t                       state, state_next;
  logic [CW-1:0]                idx, idx_next;
  logic                         pend, pend_next;
  logic [CW-1:0]                pend_addr, pend_addr_next;
  logic                         done_next;
  logic                         rd_ok, rd_ok_next;
  logic [tcw_pkg::BYTE_W-1:0]   rd_char, rd_char_next;
  logic [tcw_pkg::BYTE_W-1:0]   rd_attr, rd_attr_next;
  logic                         scr, scr_next;
  tcw_pkg::item_t               item_q;
  logic [tcw_pkg::CELL_W-1:0]   blank;
  logic [tcw_pkg::CELL_W-1:0]   item_cell;
  logic                         addr_ok;

  assign busy      = (state != S_IDLE);
  assign blank     = {fill_attr, tcw_pkg::SPACE_CODE};
  assign item_cell = {item_q.attribute, item_q.char_code};
  assign addr_ok   = XW'(item_q.cell_address) < XW'(CELLS);

  // Sequence one item through the cursor unit and the cell store
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    done_next      = 1'b0;
    rd_ok_next     = rd_ok;
    rd_char_next   = '0;
    rd_attr_next   = '0;
    scr_next       = 1'b0;
    cmd.op         = tcw_pkg::CUR_HOLD;
    cmd.char_code  = item_q.char_code;
    we             = 1'b0;
    waddr          = idx;
    wdata          = blank;
    raddr          = CW'(item_q.cell_address);
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = {tcw_pkg::FILL_RESET, tcw_pkg::SPACE_CODE};
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (item_q.func)
          tcw_pkg::FUNC_PUT: begin
            cmd.op = tcw_pkg::CUR_PUT;
            if (item_q.char_code != tcw_pkg::NEWLINE_CODE &&
                item_q.char_code != tcw_pkg::TAB_CODE) begin
              we    = 1'b1;
              waddr = cursor;
              wdata = item_cell;
            end
            if (scroll_need) begin
              idx_next   = '0;
              state_next = S_COPY;
            end else begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
          tcw_pkg::FUNC_ERASE: begin
            if (!cursor_zero) begin
              cmd.op = tcw_pkg::CUR_ERASE;
              we     = 1'b1;
              waddr  = cursor_dec;
              wdata  = blank;
            end
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          tcw_pkg::FUNC_CLEAR: begin
            idx_next   = '0;
            state_next = S_CLEAR;
          end
          tcw_pkg::FUNC_WRITE: begin
            we         = addr_ok;
            waddr      = CW'(item_q.cell_address);
            wdata      = item_cell;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          tcw_pkg::FUNC_READ: begin
            rd_ok_next = addr_ok;
            state_next = S_READ;
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (rd_ok) begin
          rd_char_next = rdata[tcw_pkg::BYTE_W-1:0];
          rd_attr_next = rdata[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_COPY: begin
        // read one row ahead, write back the cell read last cycle
        raddr          = idx + CW'(COLS);
        pend_next      = 1'b1;
        pend_addr_next = idx;
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rdata;
        end
        idx_next = idx + 1'b1;
        if (idx == COPY_LAST) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (pend) begin
          // drain the last copied cell first
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rdata;
        end else begin
          we    = 1'b1;
          wdata = blank;
          if (idx == LAST) begin
            cmd.op     = tcw_pkg::CUR_UP;
            scr_next   = 1'b1;
            done_next  = 1'b1;
            idx_next   = '0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        if (idx == LAST) begin
          cmd.op     = tcw_pkg::CUR_HOME;
          done_next  = 1'b1;
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    rd_ok     <= rd_ok_next;
    rd_char   <= rd_char_next;
    rd_attr   <= rd_attr_next;
    scr       <= scr_next;
    if (state == S_IDLE && start) begin
      item_q <= item;
    end
  end

  // Cursor register already holds the post-item value while done is high
  assign result.cursor_offset  = tcw_pkg::OFFSET_W'(cursor);
  assign result.read_char      = rd_char;
  assign result.read_attribute = rd_attr;
  assign result.scrolled       = scr;

endmodule

`default_nettype wire

// File: sv/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Text-mode screen engine: a store of SCREEN_COLUMNS x SCREEN_ROWS cells
// (character and attribute) plus a cursor.
// Command channel: drive item and raise start; the item transfers at the
// clock edge where start is high and busy is low. busy stays high until the
// item is finished. Each item returns one result on result, marked by done
// for exactly one cycle; the receiver cannot stall, so it must take it then.
// Put, erase, write-at and unused codes finish in the execute state; read-at
// adds a read state after it. A put that scrolls walks the cell store once
// through its one read port and one write port. Clear writes one cell a
// cycle. A new item can transfer in the cycle done is high.
// Register port (APB, pready always high): byte address 0 holds the fill
// attribute (reset 7) used for blanked cells.
// After reset the block runs a clearing pass, writing spaces with attribute
// 7, with busy high; register writes are taken during it.
module text_console_writer #(
  parameter int SCREEN_COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int SCREEN_ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire tcw_pkg::item_t                item,
  output logic                               busy,
  output logic                               done,
  output tcw_pkg::result_t                   result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int CW    = $clog2(CELLS);

  logic [tcw_pkg::BYTE_W-1:0] fill_attr;
  logic                       reg_hit;
  tcw_pkg::cur_cmd_t          cmd;
  logic [CW-1:0]              cursor;
  logic [CW-1:0]              cursor_dec;
  logic                       cursor_zero;
  logic                       scroll_need;
  logic                       we;
  logic [CW-1:0]              waddr;
  logic [CW-1:0]              raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  // Register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_FILL_ATTR);
  assign prdata  = reg_hit ? tcw_pkg::PDATA_W'(fill_attr) : '0;

  // Update fill attribute on a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attr <= tcw_pkg::FILL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      fill_attr <= pwdata[tcw_pkg::BYTE_W-1:0];
    end
  end

  tcw_ctrl #(
    .COLS  (SCREEN_COLUMNS),
    .CELLS (CELLS),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .fill_attr   (fill_attr),
    .cursor      (cursor),
    .cursor_dec  (cursor_dec),
    .cursor_zero (cursor_zero),
    .scroll_need (scroll_need),
    .rdata       (rdata),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .cmd         (cmd),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr)
  );

  tcw_cursor #(
    .COLS  (SCREEN_COLUMNS),
    .CELLS (CELLS),
    .CW    (CW)
  ) u_cursor (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cursor      (cursor),
    .cursor_dec  (cursor_dec),
    .cursor_zero (cursor_zero),
    .scroll_need (scroll_need)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (CW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
